// File: design/led_matrix_scan_driver_defines.svh
// Assertion macros for the LED matrix scan driver.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LED_MATRIX_SCAN_DRIVER_DEFINES_SVH
`define LED_MATRIX_SCAN_DRIVER_DEFINES_SVH

// Checks that a condition holds in the same cycle.
`define LMSD_CHECK(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define LMSD_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/lmsd_pkg.sv
// Package for the LED matrix scan driver: sequencer states, mode codes
// and the bit positions of the input and output words. Depends on nothing.
`default_nettype none

package lmsd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_SHIFT,
    ST_EDIT_RD,
    ST_EDIT_WR,
    ST_SWEEP
  } lmsd_state_t;

  localparam logic [2:0] MODE_SCAN  = 3'd0;
  localparam logic [2:0] MODE_PIXEL = 3'd1;
  localparam logic [2:0] MODE_BYTE  = 3'd2;
  localparam logic [2:0] MODE_CLEAR = 3'd3;
  localparam logic [2:0] MODE_FILL  = 3'd4;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;
  localparam int SEL_W      = 4;

  localparam int MODE_LSB  = 0;
  localparam int X_LSB     = 3;
  localparam int Y_LSB     = 9;
  localparam int VALUE_LSB = 14;

endpackage

`default_nettype wire

// File: design/led_matrix_scan_driver.sv
// LED matrix scan driver: frame store with a row-scan sequencer.
// A scan tick reads its row pair, then shifts out one word per cycle while the
// output is not stalled, COLUMN_BYTES*8 words (64 by default) in all; a pixel or
// byte edit reads its row, then writes it back; clear and fill write all rows.
// The single store read port pair and the output shifter set this sequence.
// Reset clears the row valid flags at once, so the whole store reads as zero.
// Depends on lmsd_pkg and led_matrix_scan_driver_defines.svh.
`default_nettype none
`include "led_matrix_scan_driver_defines.svh"

module led_matrix_scan_driver
  import lmsd_pkg::*;
#(
  parameter int SCAN_LINES   = 16,
  parameter int COLUMN_BYTES = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // mode[2:0], x_position[8:3], y_position[13:9], value[21:14], zero fill above
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // upper_bit[0], lower_bit[1], row_select[5:2], zero fill above
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tlast
);

  localparam int STORE_ROWS = 2 * SCAN_LINES;
  localparam int ROW_BITS   = COLUMN_BYTES * 8;
  localparam int ROW_W      = $clog2(STORE_ROWS);
  localparam int LINE_W     = $clog2(SCAN_LINES);
  localparam int COL_W      = $clog2(ROW_BITS);

  lmsd_state_t state, state_next;

  logic [2:0]          op_mode;
  logic [5:0]          op_x;
  logic [4:0]          op_y;
  logic [7:0]          op_value;

  logic [LINE_W-1:0]   line;
  logic [COL_W-1:0]    bit_count;
  logic [ROW_W-1:0]    sweep_row;

  logic [ROW_BITS-1:0] mem [STORE_ROWS];
  logic [STORE_ROWS-1:0] row_valid;
  logic [ROW_BITS-1:0] row_a;
  logic [ROW_BITS-1:0] row_b;

  logic                upper_bit;
  logic                lower_bit;
  logic [SEL_W-1:0]    row_select;

  logic [2:0]          in_mode;
  logic [5:0]          in_x;
  logic [4:0]          in_y;
  logic                in_y_ok;
  logic                accept;

  logic                rd_en;
  logic [ROW_W-1:0]    rd_addr_a;
  logic [ROW_W-1:0]    rd_addr_b;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_addr;
  logic [ROW_BITS-1:0] wr_data;
  logic                out_free;
  logic                shift_en;
  logic                last_bit;

  logic [COL_W-1:0]    pix_pos;
  logic [COL_W-1:0]    byte_pos;
  logic [ROW_BITS-1:0] pix_mask;
  logic [ROW_BITS-1:0] byte_mask;
  logic [ROW_BITS-1:0] byte_data;
  logic [ROW_BITS-1:0] edit_row;
  logic [SEL_W-1:0]    sel_now;

  assign in_mode  = s_tdata[MODE_LSB +: 3];
  assign in_x     = s_tdata[X_LSB +: 6];
  assign in_y     = s_tdata[Y_LSB +: 5];
  assign in_y_ok  = int'(in_y) < STORE_ROWS;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign last_bit = bit_count == COL_W'(ROW_BITS - 1);
  assign sel_now  = SEL_W'(SCAN_LINES - 1 - int'(line));

  assign pix_pos   = COL_W'(ROW_BITS - 1 - int'(op_x));
  assign byte_pos  = COL_W'(8 * (COLUMN_BYTES - 1 - int'(op_x)));
  assign pix_mask  = ROW_BITS'(1) << pix_pos;
  assign byte_mask = ROW_BITS'(8'hff) << byte_pos;
  assign byte_data = ROW_BITS'(op_value) << byte_pos;

  always_comb begin
    if (op_mode == MODE_PIXEL) begin
      edit_row = (op_value != 8'd0) ? (row_a | pix_mask) : (row_a & ~pix_mask);
    end else begin
      edit_row = (row_a & ~byte_mask) | byte_data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (in_mode)
            MODE_SCAN: state_next = ST_SCAN_RD;
            MODE_PIXEL: begin
              if (int'(in_x) < ROW_BITS && in_y_ok) state_next = ST_EDIT_RD;
            end
            MODE_BYTE: begin
              if (int'(in_x) < COLUMN_BYTES && in_y_ok) state_next = ST_EDIT_RD;
            end
            MODE_CLEAR: state_next = ST_SWEEP;
            MODE_FILL: state_next = ST_SWEEP;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_RD: state_next = ST_SCAN_SHIFT;
      ST_SCAN_SHIFT: begin
        if (shift_en && last_bit) state_next = ST_IDLE;
      end
      ST_EDIT_RD: state_next = ST_EDIT_WR;
      ST_EDIT_WR: state_next = ST_IDLE;
      ST_SWEEP: begin
        if (sweep_row == ROW_W'(STORE_ROWS - 1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr_a = ROW_W'(line);
    rd_addr_b = ROW_W'(line) + ROW_W'(SCAN_LINES);
    wr_en     = 1'b0;
    wr_addr   = ROW_W'(op_y);
    wr_data   = edit_row;
    shift_en  = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_SCAN_RD: rd_en = 1'b1;
      ST_SCAN_SHIFT: shift_en = out_free;
      ST_EDIT_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = ROW_W'(op_y);
      end
      ST_EDIT_WR: wr_en = 1'b1;
      ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_row;
        wr_data = (op_mode == MODE_FILL) ? '1 : '0;
      end
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      line      <= '0;
      bit_count <= '0;
      sweep_row <= '0;
      row_valid <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) sweep_row <= '0;
      else if (state == ST_SWEEP) sweep_row <= sweep_row + 1'b1;
      if (state == ST_SCAN_RD) bit_count <= '0;
      else if (shift_en) bit_count <= bit_count + 1'b1;
      if (shift_en && last_bit) begin
        line <= (line == LINE_W'(SCAN_LINES - 1)) ? '0 : line + 1'b1;
      end
      if (wr_en) row_valid[wr_addr] <= 1'b1;
      if (shift_en) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode  <= in_mode;
      op_x     <= in_x;
      op_y     <= in_y;
      op_value <= s_tdata[VALUE_LSB +: 8];
    end
    if (shift_en) begin
      upper_bit  <= row_a[0];
      lower_bit  <= row_b[0];
      row_select <= sel_now;
      m_tlast    <= last_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      row_a <= row_valid[rd_addr_a] ? mem[rd_addr_a] : '0;
      row_b <= row_valid[rd_addr_b] ? mem[rd_addr_b] : '0;
    end else if (shift_en) begin
      row_a <= row_a >> 1;
      row_b <= row_b >> 1;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - SEL_W - 2){1'b0}}, row_select, lower_bit, upper_bit};

  `LMSD_CHECK(a_last_ends_scan, !(m_tvalid && m_tlast && state == ST_SCAN_SHIFT) || bit_count == '0, "last word held past tick")
  `LMSD_CHECK_NEXT(a_shift_loads_word, state == ST_SCAN_SHIFT && out_free, m_tvalid, "free output slot not filled during scan")
  `LMSD_CHECK_NEXT(a_line_steps_on_last, shift_en && last_bit, m_tvalid && m_tlast && state == ST_IDLE, "final word did not end the tick")
  `LMSD_CHECK(a_line_only_at_last, $stable(line) || (m_tvalid && m_tlast), "scan line moved without a final word")

endmodule

`default_nettype wire

// File: tb/led_matrix_scan_driver_tb.sv
// Self-checking testbench for led_matrix_scan_driver: directed table, then random edits and
// scan ticks, with random gaps on both stream sides and a model of the frame store.
// Depends on lmsd_pkg and the led_matrix_scan_driver RTL.
`default_nettype none

module led_matrix_scan_driver_tb;
  import lmsd_pkg::*;

  localparam int SCAN_LINES   = 16;
  localparam int COLUMN_BYTES = 8;
  localparam int STORE_ROWS   = 2 * SCAN_LINES;
  localparam int PIXEL_COLS   = COLUMN_BYTES * 8;
  localparam int ITEM_TARGET  = 220;
  localparam int DRAIN_CYCLES = 2 * STORE_ROWS + 16;

  localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [2:0] mode;
    logic [5:0] x_pos;
    logic [4:0] y_pos;
    logic [7:0] value;
  } panel_cmd_t;

  typedef struct packed {
    logic       upper_bit;
    logic       lower_bit;
    logic [3:0] row_select;
    logic       last;
  } bit_pair_t;

  // A row with known set gives a scan tick whose every pair is typed in directly.
  typedef struct packed {
    panel_cmd_t cmd;
    logic       known;
    logic       known_upper;
    logic       known_lower;
    logic [3:0] known_select;
  } cmd_row_t;

  localparam int NUM_ROWS = 22;

  cmd_row_t cmd_rows [NUM_ROWS] = '{
    '{'{MODE_SCAN,      6'd0,  5'd0,  8'h00}, 1'b1, 1'b0, 1'b0, 4'd15},
    '{'{MODE_FILL,      6'd0,  5'd0,  8'h00}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_SCAN,      6'd0,  5'd0,  8'h00}, 1'b1, 1'b1, 1'b1, 4'd14},
    '{'{MODE_CLEAR,     6'd63, 5'd31, 8'hff}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_SCAN,      6'd63, 5'd31, 8'hff}, 1'b1, 1'b0, 1'b0, 4'd13},
    '{'{MODE_PIXEL,     6'd0,  5'd3,  8'h01}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_PIXEL,     6'd63, 5'd19, 8'hff}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_PIXEL,     6'd31, 5'd3,  8'h80}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_BYTE,      6'd0,  5'd3,  8'ha5}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_BYTE,      6'd7,  5'd19, 8'h5a}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_BYTE,      6'd8,  5'd3,  8'hff}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_BYTE,      6'd63, 5'd19, 8'hff}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_SPARE_LO,  6'd1,  5'd3,  8'hff}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_SPARE_MID, 6'd62, 5'd19, 8'h00}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_SPARE_HI,  6'd63, 5'd31, 8'hff}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_SCAN,      6'd0,  5'd0,  8'h00}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_FILL,      6'd0,  5'd0,  8'h00}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_PIXEL,     6'd0,  5'd20, 8'h00}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_BYTE,      6'd3,  5'd4,  8'h00}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_SCAN,      6'd0,  5'd0,  8'h00}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_PIXEL,     6'd63, 5'd31, 8'h00}, 1'b0, 1'b0, 1'b0, 4'd0},
    '{'{MODE_BYTE,      6'd7,  5'd0,  8'hff}, 1'b0, 1'b0, 1'b0, 4'd0}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  logic [7:0] panel_image [STORE_ROWS][COLUMN_BYTES];
  int         panel_line;
  bit_pair_t  pending_pairs [$];
  int         error_count;
  int         pairs_seen;

  led_matrix_scan_driver #(
    .SCAN_LINES   (SCAN_LINES),
    .COLUMN_BYTES (COLUMN_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void advance_line();
    panel_line = (panel_line + 1) % SCAN_LINES;
  endfunction

  function automatic void predict_scan();
    bit_pair_t p;
    logic [7:0] hi_byte;
    logic [7:0] lo_byte;
    for (int b = 0; b < COLUMN_BYTES; b++) begin
      hi_byte = panel_image[panel_line][b];
      lo_byte = panel_image[panel_line + SCAN_LINES][b];
      for (int i = 0; i < 8; i++) begin
        p.upper_bit  = hi_byte[i];
        p.lower_bit  = lo_byte[i];
        p.row_select = 4'(SCAN_LINES - 1 - panel_line);
        p.last       = (b == COLUMN_BYTES - 1) && (i == 7);
        pending_pairs.push_back(p);
      end
    end
    advance_line();
  endfunction

  function automatic void fill_image(input logic [7:0] v);
    for (int r = 0; r < STORE_ROWS; r++)
      for (int b = 0; b < COLUMN_BYTES; b++)
        panel_image[r][b] = v;
  endfunction

  function automatic void apply_cmd(input panel_cmd_t c);
    int col;
    case (c.mode)
      MODE_SCAN: predict_scan();
      MODE_PIXEL: begin
        if (c.x_pos < PIXEL_COLS && c.y_pos < STORE_ROWS) begin
          col = PIXEL_COLS - 1 - int'(c.x_pos);
          panel_image[c.y_pos][col / 8][col % 8] = (c.value != 8'h00);
        end
      end
      MODE_BYTE: begin
        if (c.x_pos < COLUMN_BYTES && c.y_pos < STORE_ROWS)
          panel_image[c.y_pos][COLUMN_BYTES - 1 - int'(c.x_pos)] = c.value;
      end
      MODE_CLEAR: fill_image(8'h00);
      MODE_FILL: fill_image(8'hff);
      default: ;
    endcase
  endfunction

  task automatic send_cmd(input panel_cmd_t c, input int gap);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[MODE_LSB +: 3]  = c.mode;
    d[X_LSB +: 6]     = c.x_pos;
    d[Y_LSB +: 5]     = c.y_pos;
    d[VALUE_LSB +: 8] = c.value;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic int draw_gap(input int n);
    return ((n / 32) % 3 == 2) ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic panel_cmd_t random_cmd();
    panel_cmd_t c;
    int pick;
    c.x_pos = 6'($urandom_range(0, PIXEL_COLS - 1));
    c.y_pos = 5'($urandom_range(0, STORE_ROWS - 1));
    c.value = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 30) c.mode = MODE_SCAN;
    else if (pick < 55) c.mode = MODE_PIXEL;
    else if (pick < 82) begin
      c.mode = MODE_BYTE;
      if ($urandom_range(0, 99) < 85)
        c.x_pos = 6'($urandom_range(0, COLUMN_BYTES - 1));
      else
        c.x_pos = 6'($urandom_range(COLUMN_BYTES, PIXEL_COLS - 1));
    end
    else if (pick < 87) c.mode = MODE_CLEAR;
    else if (pick < 92) c.mode = MODE_FILL;
    else c.mode = 3'(MODE_SPARE_LO + $urandom_range(0, 2));
    return c;
  endfunction

  initial begin
    bit_pair_t p;
    int        sent;
    panel_cmd_t c;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    error_count = 0;
    pairs_seen  = 0;
    panel_line  = 0;
    fill_image(8'h00);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    sent = 0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_cmd(cmd_rows[r].cmd, draw_gap(sent));
      sent++;
      if (cmd_rows[r].known) begin
        for (int k = 0; k < PIXEL_COLS; k++) begin
          p.upper_bit  = cmd_rows[r].known_upper;
          p.lower_bit  = cmd_rows[r].known_lower;
          p.row_select = cmd_rows[r].known_select;
          p.last       = (k == PIXEL_COLS - 1);
          pending_pairs.push_back(p);
        end
        advance_line();
      end else begin
        apply_cmd(cmd_rows[r].cmd);
      end
    end
    while (sent < ITEM_TARGET) begin
      c = random_cmd();
      send_cmd(c, draw_gap(sent));
      sent++;
      apply_cmd(c);
    end
    s_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    bit_pair_t want;
    int        stall;
    @(negedge rst);
    forever begin
      stall = ((pairs_seen / 256) % 3 == 1) ? 0 : int'($urandom_range(0, 6));
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      pairs_seen++;
      if (pending_pairs.size() == 0) begin
        $error("unexpected word: tdata %h tlast %b", m_tdata, m_tlast);
        error_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (m_tdata[0] !== want.upper_bit) begin
          $error("upper_bit: expected %b, got %b", want.upper_bit, m_tdata[0]);
          error_count++;
        end
        if (m_tdata[1] !== want.lower_bit) begin
          $error("lower_bit: expected %b, got %b", want.lower_bit, m_tdata[1]);
          error_count++;
        end
        if (m_tdata[5:2] !== want.row_select) begin
          $error("row_select: expected %0d, got %0d", want.row_select, m_tdata[5:2]);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
